// File: hdl/mf7_pkg.sv
// shared constants and codes for the 7x7 median filter
package mf7_pkg;

  localparam int unsigned PIX_W          = 8;
  localparam int unsigned CFG_W          = 10;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned MAX_WIDTH_DEF  = 512;
  localparam int unsigned WINDOW_DEF     = 7;
  localparam int unsigned MAX_HEIGHT     = 512;
  localparam int unsigned SIZE_RESET     = 512;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // request kinds
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

endpackage

// File: hdl/mf7_if.sv
// stream interfaces for pixel requests and filtered results
interface mf7_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [mf7_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, output func, output pixel, input ready);
  modport sink   (input valid, input func, input pixel, output ready);
endinterface

interface mf7_out_if;
  logic                       valid;
  logic                       ready;
  logic [mf7_pkg::PIX_W-1:0]  filtered_pixel;
  logic                       frame_last;

  modport source (output valid, output filtered_pixel, output frame_last, input ready);
  modport sink   (input valid, input filtered_pixel, input frame_last, output ready);
endinterface

// File: hdl/median_filter_7x7_unit.sv
// top level of the streaming 7x7 median filter
// pixels enter on in_if in raster order, one request per pixel; a drain
// request (func = 1) carries no pixel and only pushes out a delayed result.
// results leave on out_if in the same raster order, delayed by three lines
// plus three pixels; frame_last marks the final pixel of each frame.
// the user must write line_width and frame_height through the cfg port only
// while idle; the block does not enforce it. values saturate to the window
// size and the maximum sizes. a request that yields no result leaves the
// block idle. a border result passes the position, address and border steps
// into the output register; an interior result reads its 49 taps one per
// cycle through the single read port of the line store, waits for the last
// tap to load and runs the bit-serial rank select, plus position, address
// and output steps. no new request is taken until the pending result is in
// the output register. the first result after a size change recovers its row
// and column from the output count by bit-serial division, or resets both on wrap.
// the output register parts the two sides: a new request is taken while a
// result waits; when the receiver stalls, the next result waits in the
// block and no further request is taken until it is handed over.
// reset restores sizes of 512 and empties all counters; the line store is
// not cleared, and needs no clearing pass.
module median_filter_7x7_unit #(
  parameter int unsigned MAX_WIDTH   = mf7_pkg::MAX_WIDTH_DEF,
  parameter int unsigned WINDOW_SIZE = mf7_pkg::WINDOW_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mf7_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mf7_pkg::CFG_W-1:0]       cfg_data_i,
  mf7_in_if.sink                          in_if,
  mf7_out_if.source                       out_if
);
  import mf7_pkg::*;

  localparam int unsigned HALF = (WINDOW_SIZE - 1) / 2;
  localparam int unsigned TAPS = WINDOW_SIZE * WINDOW_SIZE;
  localparam int unsigned RING = WINDOW_SIZE * MAX_WIDTH;
  localparam int unsigned AW   = $clog2(RING);
  localparam int unsigned XW   = AW + 1;
  localparam int unsigned PW   = $clog2(RING + 1);
  localparam int unsigned OCW  = 2 * CFG_W;
  localparam int unsigned IW   = $clog2(TAPS);
  localparam int unsigned DW   = $clog2(WINDOW_SIZE);
  localparam int unsigned KW   = $clog2(OCW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_POS, S_DIV, S_ADDR, S_TAP, S_WAIT, S_SEL, S_BORDER, S_OUT
  } state_e;

  state_e            state_q;
  logic [CFG_W-1:0]  cfg_w_q, cfg_h_q;
  logic [AW-1:0]     wp_q;
  logic [PW-1:0]     pend_q;
  logic [OCW-1:0]    oc_q;
  logic [CFG_W-1:0]  row_q, col_q;
  logic              pos_ok_q;
  logic [AW-1:0]     base_q;
  logic              border_q;
  logic [AW-1:0]     addr_q, rowb_q;
  logic [DW-1:0]     dc_q;
  logic [IW-1:0]     tap_q, ld_idx_q;
  logic              ld_v_q;
  logic [KW-1:0]     div_cnt_q;
  logic [CFG_W:0]    div_rem_q;
  logic [OCW-1:0]    div_quo_q;
  logic [PIX_W-1:0]  res_q;
  logic              out_valid_q;
  logic [PIX_W-1:0]  out_pix_q;
  logic              out_last_q;

  logic [CFG_W-1:0]  w_c, h_c;
  logic [OCW-1:0]    total_c;
  logic [PW-1:0]     delay_c, pend_n;
  logic [XW-1:0]     wpx, pdx, basex, offx, rbsum;
  logic [AW-1:0]     base_c, start_c, rowb_n;
  logic              border_c;
  logic [CFG_W:0]    rem_sh, rem_n;
  logic              quo_bit;
  logic              in_fire;
  logic [AW-1:0]     raddr;
  logic [PIX_W-1:0]  rdata;
  logic              sel_done;
  logic [PIX_W-1:0]  sel_result;

  // saturated frame geometry
  always_comb begin
    if (cfg_w_q < CFG_W'(WINDOW_SIZE))    w_c = CFG_W'(WINDOW_SIZE);
    else if (cfg_w_q > MAX_WIDTH)         w_c = CFG_W'(MAX_WIDTH);
    else                                  w_c = cfg_w_q;
    if (cfg_h_q < CFG_W'(WINDOW_SIZE))    h_c = CFG_W'(WINDOW_SIZE);
    else if (cfg_h_q > MAX_HEIGHT)        h_c = CFG_W'(MAX_HEIGHT);
    else                                  h_c = cfg_h_q;
    total_c = OCW'(w_c) * OCW'(h_c);
    delay_c = PW'(w_c) * PW'(HALF) + PW'(HALF);
  end

  assign pend_n = (pend_q < PW'(RING)) ? pend_q + PW'(1) : pend_q;

  // ring position of the centre pixel and of the window's top-left tap
  always_comb begin
    wpx     = XW'(wp_q);
    pdx     = XW'(pend_q);
    base_c  = (wpx >= pdx) ? AW'(wpx - pdx) : AW'(wpx + XW'(RING) - pdx);
    basex   = XW'(base_q);
    offx    = XW'(delay_c);
    start_c = (basex >= offx) ? AW'(basex - offx) : AW'(basex + XW'(RING) - offx);
    rbsum   = XW'(rowb_q) + XW'(w_c);
    rowb_n  = (rbsum >= XW'(RING)) ? AW'(rbsum - XW'(RING)) : AW'(rbsum);
    border_c = (row_q < CFG_W'(HALF)) || (row_q >= h_c - CFG_W'(HALF)) ||
               (col_q < CFG_W'(HALF)) || (col_q >= w_c - CFG_W'(HALF));
  end

  // one restoring division step for row and column recovery
  always_comb begin
    rem_sh  = {div_rem_q[CFG_W-1:0], div_quo_q[OCW-1]};
    quo_bit = (rem_sh >= {1'b0, w_c});
    rem_n   = quo_bit ? rem_sh - {1'b0, w_c} : rem_sh;
  end

  assign in_fire  = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_IDLE);
  assign raddr    = (state_q == S_TAP) ? addr_q : base_q;

  mf7_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RING)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (in_fire && (in_if.func == FUNC_PIXEL)),
    .waddr_i (wp_q),
    .wdata_i (in_if.pixel),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mf7_select #(
    .TAPS (TAPS)
  ) u_select (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ld_v_q),
    .load_idx_i  (ld_idx_q),
    .load_data_i (rdata),
    .start_i     (state_q == S_WAIT),
    .done_o      (sel_done),
    .result_o    (sel_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_w_q     <= CFG_W'(SIZE_RESET);
      cfg_h_q     <= CFG_W'(SIZE_RESET);
      wp_q        <= '0;
      pend_q      <= '0;
      oc_q        <= '0;
      row_q       <= '0;
      col_q       <= '0;
      pos_ok_q    <= 1'b1;
      base_q      <= '0;
      border_q    <= 1'b0;
      addr_q      <= '0;
      rowb_q      <= '0;
      dc_q        <= '0;
      tap_q       <= '0;
      ld_idx_q    <= '0;
      ld_v_q      <= 1'b0;
      div_cnt_q   <= '0;
      div_rem_q   <= '0;
      div_quo_q   <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_pix_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      ld_v_q <= 1'b0;
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end

      // a width or height change invalidates the tracked row and column
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LINE_WIDTH: begin
            cfg_w_q  <= cfg_data_i;
            pos_ok_q <= 1'b0;
          end
          CFG_FRAME_HEIGHT: begin
            cfg_h_q  <= cfg_data_i;
            pos_ok_q <= 1'b0;
          end
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_if.func == FUNC_PIXEL) begin
              wp_q   <= (wp_q == AW'(RING - 1)) ? '0 : wp_q + AW'(1);
              pend_q <= pend_n;
              if (pend_n > delay_c) begin
                state_q <= S_POS;
              end
            end else if (pend_q != '0) begin
              state_q <= S_POS;
            end
          end
        end
        S_POS: begin
          if (oc_q >= total_c) begin
            // count beyond a shrunk frame wraps to its start
            oc_q     <= '0;
            row_q    <= '0;
            col_q    <= '0;
            pos_ok_q <= 1'b1;
          end else if (!pos_ok_q) begin
            div_rem_q <= '0;
            div_quo_q <= oc_q;
            div_cnt_q <= KW'(OCW);
            state_q   <= S_DIV;
          end else begin
            base_q   <= base_c;
            border_q <= border_c;
            state_q  <= S_ADDR;
          end
        end
        S_DIV: begin
          div_rem_q <= rem_n;
          div_quo_q <= {div_quo_q[OCW-2:0], quo_bit};
          div_cnt_q <= div_cnt_q - KW'(1);
          if (div_cnt_q == KW'(1)) begin
            row_q    <= CFG_W'({div_quo_q[OCW-2:0], quo_bit});
            col_q    <= rem_n[CFG_W-1:0];
            pos_ok_q <= 1'b1;
            state_q  <= S_POS;
          end
        end
        S_ADDR: begin
          if (border_q) begin
            state_q <= S_BORDER;
          end else begin
            addr_q  <= start_c;
            rowb_q  <= start_c;
            dc_q    <= '0;
            tap_q   <= '0;
            state_q <= S_TAP;
          end
        end
        S_TAP: begin
          ld_v_q   <= 1'b1;
          ld_idx_q <= tap_q;
          tap_q    <= tap_q + IW'(1);
          if (dc_q == DW'(WINDOW_SIZE - 1)) begin
            rowb_q <= rowb_n;
            addr_q <= rowb_n;
            dc_q   <= '0;
          end else begin
            addr_q <= (addr_q == AW'(RING - 1)) ? '0 : addr_q + AW'(1);
            dc_q   <= dc_q + DW'(1);
          end
          if (tap_q == IW'(TAPS - 1)) begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          state_q <= S_SEL;
        end
        S_SEL: begin
          if (sel_done) begin
            res_q   <= sel_result;
            state_q <= S_OUT;
          end
        end
        S_BORDER: begin
          res_q   <= rdata;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q <= 1'b1;
            out_pix_q   <= res_q;
            out_last_q  <= (oc_q == total_c - OCW'(1));
            if (oc_q + OCW'(1) >= total_c) begin
              oc_q  <= '0;
              row_q <= '0;
              col_q <= '0;
            end else begin
              oc_q <= oc_q + OCW'(1);
              if (col_q + CFG_W'(1) == w_c) begin
                col_q <= '0;
                row_q <= row_q + CFG_W'(1);
              end else begin
                col_q <= col_q + CFG_W'(1);
              end
            end
            pend_q  <= pend_q - PW'(1);
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.filtered_pixel = out_pix_q;
  assign out_if.frame_last     = out_last_q;

endmodule

// File: hdl/mf7_ram.sv
// generic simple dual-port ram with registered read
module mf7_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/mf7_select.sv
// window registers and bit-serial rank select (one result bit per cycle)
module mf7_select #(
  parameter int unsigned TAPS = 49
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [$clog2(TAPS)-1:0]     load_idx_i,
  input  logic [mf7_pkg::PIX_W-1:0]   load_data_i,
  input  logic                        start_i,
  output logic                        done_o,
  output logic [mf7_pkg::PIX_W-1:0]   result_o
);
  import mf7_pkg::*;

  localparam int unsigned CW = $clog2(TAPS + 1);
  localparam int unsigned BW = $clog2(PIX_W);

  logic [PIX_W-1:0] win_q [TAPS];
  logic [PIX_W-1:0] prefix_q;
  logic [CW-1:0]    rank_q;
  logic [BW-1:0]    bit_q;
  logic             busy_q;
  logic             done_q;
  logic [PIX_W-1:0] hi_mask;
  logic [CW-1:0]    cnt;

  // count candidates that share the settled upper bits and have a zero here
  always_comb begin
    hi_mask = ({PIX_W{1'b1}} << bit_q) << 1;
    cnt     = '0;
    for (int i = 0; i < TAPS; i++) begin
      if ((((win_q[i] ^ prefix_q) & hi_mask) == '0) && !win_q[i][bit_q]) begin
        cnt = cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      win_q[load_idx_i] <= load_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      bit_q    <= '0;
      rank_q   <= '0;
      prefix_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q   <= 1'b1;
        bit_q    <= BW'(PIX_W - 1);
        rank_q   <= CW'((TAPS - 1) / 2);
        prefix_q <= '0;
      end else if (busy_q) begin
        if (rank_q >= cnt) begin
          prefix_q[bit_q] <= 1'b1;
          rank_q          <= rank_q - cnt;
        end
        if (bit_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          bit_q <= bit_q - BW'(1);
        end
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = prefix_q;

endmodule
